// ===== sv/bmhq_pkg.sv =====
// Package for the binary min-heap priority queue.
// Holds the command and result beat types and the command and status codes.
// No dependencies.
package bmhq_pkg;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
  localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] key;
  } request_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic               is_empty;
    logic [10:0]        entry_count;
    logic [1:0]         status;
  } result_t;

endpackage

// ===== sv/binary_min_heap_queue.sv =====
// Top level of the binary min-heap priority queue: sequencer and heap memory.
// Depends on bmhq_pkg for the beat types and codes.
//
//   Port     Dir  Beat
//   request  in   command beat, taken when start is high and busy is low
//   result   out  result beat, valid for the one cycle that done is high
//
// A push sifts the new key up, one parent read and compare per level, until a compare stops
// it or it reaches the root. A pop loads the last entry and sifts it down a level at a time
// until a compare stops it or it has no child. A pop that empties the queue skips the
// descent, and a refused command goes straight to the result beat. The worst case is a
// pop that sinks to the bottom. Each level is one registered heap memory read and one compare.
// The result beat comes in the cycle where busy falls, and a new command can be taken then.
// Reset empties the queue at once; the memory is not cleared.
// The receiver cannot stall: each result beat is marked by done for one cycle only.
module binary_min_heap_queue #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bmhq_pkg::request_t  request,
  output logic                busy,
  output logic                done,
  output bmhq_pkg::result_t   result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  state_t state;
  logic [AW-1:0] pos;
  logic signed [31:0] val;
  logic [CW-1:0] count;
  logic signed [31:0] root;
  logic [1:0] status;

  logic signed [31:0] heap [DEPTH];
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;

  logic [AW-1:0] pos_m1;
  logic [AW-1:0] parent;
  logic [AW+1:0] lc;
  logic [AW+1:0] rc;
  logic [AW+1:0] count_x;
  logic lc_ok;
  logic rc_ok;
  logic pick_right;
  logic signed [31:0] child;
  logic [AW-1:0] pick;
  logic [CW-1:0] count_m1;
  logic [CW+10:0] count_wide;

  assign busy = (state != S_IDLE);

  assign pos_m1 = pos - 1'b1;
  assign parent = pos_m1 >> 1;
  assign lc = {1'b0, pos, 1'b1};
  assign rc = lc + 1'b1;
  assign count_x = (AW + 2)'(count);
  assign lc_ok = (lc < count_x);
  assign rc_ok = (rc < count_x);
  assign pick_right = rc_ok && (rd_b < rd_a);
  assign child = pick_right ? rd_b : rd_a;
  assign pick = pick_right ? rc[AW-1:0] : lc[AW-1:0];
  assign count_m1 = count - 1'b1;
  assign count_wide = (CW + 11)'(count);

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = pos;
    mem_wdata = val;
    rd_addr_a = lc[AW-1:0];
    rd_addr_b = rc[AW-1:0];
    unique case (state)
      S_POP_RD: begin
        rd_addr_a = count[AW-1:0];
      end
      S_UP_RD: begin
        rd_addr_a = parent;
        if (pos == '0) begin
          mem_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (val < rd_a) begin
          mem_wdata = rd_a;
        end
      end
      S_DN_RD: begin
        if (!lc_ok) begin
          mem_we = 1'b1;
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (val > child) begin
          mem_wdata = child;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap[mem_waddr] <= mem_wdata;
    end
    rd_a <= heap[rd_addr_a];
    rd_b <= heap[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done <= 1'b0;
      status <= bmhq_pkg::STATUS_OK;
    end else begin
      done <= 1'b0;
      if (mem_we && (mem_waddr == '0)) begin
        root <= mem_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            status <= bmhq_pkg::STATUS_OK;
            if (request.cmd == bmhq_pkg::CMD_POP) begin
              if (count == '0) begin
                status <= bmhq_pkg::STATUS_POP_EMPTY;
                state <= S_FIN;
              end else begin
                count <= count_m1;
                state <= S_POP_RD;
              end
            end else begin
              if (count == CW'(DEPTH)) begin
                status <= bmhq_pkg::STATUS_PUSH_FULL;
                state <= S_FIN;
              end else begin
                pos <= count[AW-1:0];
                val <= request.key;
                count <= count + 1'b1;
                state <= S_UP_RD;
              end
            end
          end
        end
        S_POP_RD: begin
          pos <= '0;
          state <= S_POP_LD;
        end
        S_POP_LD: begin
          val <= rd_a;
          state <= (count == '0) ? S_FIN : S_DN_RD;
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_FIN : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (val < rd_a) begin
            pos <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_DN_RD: begin
          state <= lc_ok ? S_DN_CMP : S_FIN;
        end
        S_DN_CMP: begin
          if (val > child) begin
            pos <= pick;
            state <= S_DN_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done <= 1'b1;
          result.min_value <= (count == '0) ? 32'sd0 : root;
          result.is_empty <= (count == '0);
          result.entry_count <= count_wide[10:0];
          result.status <= status;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
